// File: rtl/xtea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA package
// Shared types, constants and round schedule for the pipelined XTEA unit.
// ----------------------------------------------------------------------------
package xtea_pkg;

   // Number of XTEA round pairs; every pair is split into two half rounds.
   localparam int ROUND_PAIRS = 32;
   localparam int HALF_ROUNDS = 2 * ROUND_PAIRS;

   localparam int WORD_W     = 32;
   localparam int KEY_WORDS  = 4;
   localparam int KEY_SEL_W  = 2;
   localparam int CSR_INDEX_W = 2;

   localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

   // Register indexes of the key words.
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD0 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD1 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD3 = 2'd3;

   // Key after reset.
   localparam logic [WORD_W-1:0] KEY_RESET0 = 32'h6C0A_5452;
   localparam logic [WORD_W-1:0] KEY_RESET1 = 32'h0382_7D0F;
   localparam logic [WORD_W-1:0] KEY_RESET2 = 32'h3A17_0B92;
   localparam logic [WORD_W-1:0] KEY_RESET3 = 32'h16DB_7FC2;

   // Action codes.
   localparam logic ACTION_ENCRYPT = 1'b0;
   localparam logic ACTION_DECRYPT = 1'b1;

   // One block in flight.
   typedef struct packed {
      logic              action;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
   } xtea_item_type;

   // Fixed schedule of one half-round stage.
   typedef struct packed {
      logic                 odd;
      logic [WORD_W-1:0]    sum_enc;
      logic [WORD_W-1:0]    sum_dec;
      logic [KEY_SEL_W-1:0] sel_enc;
      logic [KEY_SEL_W-1:0] sel_dec;
   } xtea_round_const_type;

   // Schedule of half round k. Encryption updates y on even and z on odd
   // half rounds; decryption updates z on even and y on odd half rounds.
   // The word y always selects its key with sum[1:0], z with sum[12:11].
   function automatic xtea_round_const_type round_const(input int k);
      xtea_round_const_type rc;
      logic [WORD_W-1:0]    n_enc;
      logic [WORD_W-1:0]    n_dec;
      n_enc      = WORD_W'((k + 1) >> 1);
      n_dec      = WORD_W'(ROUND_PAIRS - ((k + 1) >> 1));
      rc.odd     = 1'(k & 1);
      rc.sum_enc = WORD_W'(n_enc * DELTA);
      rc.sum_dec = WORD_W'(n_dec * DELTA);
      rc.sel_enc = rc.odd ? rc.sum_enc[12:11] : rc.sum_enc[1:0];
      rc.sel_dec = rc.odd ? rc.sum_dec[1:0] : rc.sum_dec[12:11];
      return rc;
   endfunction

endpackage
`default_nettype wire

// File: rtl/xtea_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One registered half round; works in either direction for the item's action.
// ----------------------------------------------------------------------------
module xtea_round
   import xtea_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire xtea_round_const_type rc,
   input  wire logic [WORD_W-1:0]    key_enc,
   input  wire logic [WORD_W-1:0]    key_dec,
   input  wire logic                 in_valid,
   input  wire xtea_item_type        in_item,
   output logic                      out_valid,
   output xtea_item_type             out_item
);

   logic              valid_ff;
   xtea_item_type     item_ff;
   xtea_item_type     item_in;
   logic              target_y;
   logic [WORD_W-1:0] sum;
   logic [WORD_W-1:0] key;
   logic [WORD_W-1:0] src;
   logic [WORD_W-1:0] dst;
   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] upd;

   // Pick the word to update, the word that feeds the mix, and the constants.
   always_comb begin
      target_y = (in_item.action == ACTION_ENCRYPT) ^ rc.odd;
      sum      = (in_item.action == ACTION_DECRYPT) ? rc.sum_dec : rc.sum_enc;
      key      = (in_item.action == ACTION_DECRYPT) ? key_dec : key_enc;
      src      = target_y ? in_item.z : in_item.y;
      dst      = target_y ? in_item.y : in_item.z;
   end

   // Mixing function and the add or subtract into the target word.
   always_comb begin
      mix = (((src << 4) ^ (src >> 5)) + src) ^ (sum + key);
      upd = (in_item.action == ACTION_DECRYPT) ? (dst - mix) : (dst + mix);
      item_in = in_item;
      if (target_y) begin
         item_in.y = upd;
      end else begin
         item_in.z = upd;
      end
   end

   // Valid bit; cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// File: rtl/xtea_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA output register
// Holds the finished item for the result channel and decides when the
// pipeline may advance.
// ----------------------------------------------------------------------------
module xtea_out_reg
   import xtea_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              last_valid,
   input  wire xtea_item_type     last_item,
   output logic                   pipe_enable,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [WORD_W-1:0]      rsp_out_first,
   output logic [WORD_W-1:0]      rsp_out_second
);

   logic          rsp_valid_ff;
   xtea_item_type rsp_item_ff;
   logic          load;

   // The register can take a new item when it is empty or being taken.
   // The pipeline only has to hold when a finished item cannot move on.
   always_comb begin
      load        = !rsp_valid_ff || !rsp_stall;
      pipe_enable = !last_valid || load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff <= last_item;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_first  = rsp_item_ff.y;
   assign rsp_out_second = rsp_item_ff.z;

endmodule
`default_nettype wire

// File: rtl/xtea_block_cipher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA block cipher unit
// Fully unrolled XTEA pipeline: encrypts or decrypts one 64-bit block per
// cycle unless the pipeline holds, with a 128-bit key held in four key registers.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_stall   action, block_first, block_second
//   rsp_      out        rsp_valid / rsp_stall   out_first, out_second
//   csr_      in         csr_write_enable        csr_index, csr_write_data
//
// One item enters per cycle while the pipeline does not hold; each of the 64 half
// rounds is one register stage, and the output register follows the last one.
// Reset clears all valid bits and loads the default key.
// The pipeline holds as a whole only while its last stage has an item and the
// output register holds a stalled item; until then new items keep entering.
// ----------------------------------------------------------------------------
module xtea_block_cipher_unit
   import xtea_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_action,
   input  wire logic [WORD_W-1:0]      req_block_first,
   input  wire logic [WORD_W-1:0]      req_block_second,
   // Result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [WORD_W-1:0]           rsp_out_first,
   output logic [WORD_W-1:0]           rsp_out_second,
   // Configuration port
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]      csr_write_data
);

   logic [WORD_W-1:0] key_ff [KEY_WORDS];
   logic              stage_valid [HALF_ROUNDS+1];
   xtea_item_type     stage_item  [HALF_ROUNDS+1];
   logic              pipe_enable;

   // Key registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[CSR_KEY_WORD0] <= KEY_RESET0;
         key_ff[CSR_KEY_WORD1] <= KEY_RESET1;
         key_ff[CSR_KEY_WORD2] <= KEY_RESET2;
         key_ff[CSR_KEY_WORD3] <= KEY_RESET3;
      end else if (csr_write_enable) begin
         key_ff[csr_index] <= csr_write_data;
      end
   end

   // Pipeline entry.
   always_comb begin
      stage_valid[0]        = req_valid;
      stage_item[0].action  = req_action;
      stage_item[0].y       = req_block_first;
      stage_item[0].z       = req_block_second;
      req_stall             = !pipe_enable;
   end

   // One stage per half round, each with its fixed sum and key choice.
   for (genvar k = 0; k < HALF_ROUNDS; k++) begin : g_round
      localparam xtea_round_const_type RC = round_const(k);
      xtea_round u_round (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_enable),
         .rc        (RC),
         .key_enc   (key_ff[RC.sel_enc]),
         .key_dec   (key_ff[RC.sel_dec]),
         .in_valid  (stage_valid[k]),
         .in_item   (stage_item[k]),
         .out_valid (stage_valid[k+1]),
         .out_item  (stage_item[k+1])
      );
   end

   // Output register and pipeline hold control.
   xtea_out_reg u_out_reg (
      .clock          (clock),
      .reset          (reset),
      .last_valid     (stage_valid[HALF_ROUNDS]),
      .last_item      (stage_item[HALF_ROUNDS]),
      .pipe_enable    (pipe_enable),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_first  (rsp_out_first),
      .rsp_out_second (rsp_out_second)
   );

`ifndef NO_ASSERTIONS
   // An accepted item occupies the first stage in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stage_valid[1])
      else $error("accepted item did not enter the pipeline");

   // A full last stage behind a stalled output register holds the input.
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid[HALF_ROUNDS] && rsp_valid && rsp_stall) |-> req_stall)
      else $error("pipeline advanced over a blocked result");

   // A held last stage keeps its item unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid[HALF_ROUNDS] && !pipe_enable) |=>
         (stage_valid[HALF_ROUNDS] && $stable(stage_item[HALF_ROUNDS])))
      else $error("held item lost in last stage");

   // An item leaving the last stage shows up in the output register.
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid[HALF_ROUNDS] && pipe_enable) |=> rsp_valid)
      else $error("item leaving the pipeline was dropped");
`endif

endmodule
`default_nettype wire
